/* hdl/assert_macros.svh */
// Assertion helpers shared by the histogram RTL.
// The module that uses them must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define LBH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("histogram assertion failed");

// Checked at every edge, reset included
`define LBH_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("histogram assertion failed");

`endif

/* hdl/lbh_pkg.sv */
`default_nettype none
package lbh_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int SAMPLE_W = 64;
    localparam int BUCKET_W = 5;
    localparam int OUT_W    = 32;

    // Counter storage
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_BUCKETS = 18;

    // Power-of-two buckets: highest in-range value is 2^POW2_BITS
    localparam int POW2_BITS    = 15;
    // Decade buckets: bounds 10^1 .. 10^16
    localparam int DECADE_STEPS = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [FUNC_W-1:0]      func_t;
    typedef logic [BUCKET_W-1:0]    bucket_t;
    typedef logic [SAMPLE_W-1:0]    sample_t;
    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [OUT_W-1:0]       out_t;

    // Operation codes
    localparam func_t FUNC_RECORD = 2'd0;
    localparam func_t FUNC_READ   = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

    localparam bucket_t ZERO_BUCKET = bucket_t'(0);
    localparam bucket_t OVF_BUCKET  = bucket_t'(NUM_BUCKETS - 1);
    localparam cnt_t    COUNT_MAX   = {COUNT_WIDTH{1'b1}};

    localparam sample_t DECADE_BOUND [DECADE_STEPS] = '{
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000
    };

    // Classified operation held in the queue
    typedef struct packed {
        func_t   func;
        bucket_t bucket;
        logic    nonzero;
    } op_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    // Low OUT_W bits of a counter, zero-extended when the counter is narrower
    function automatic out_t to_out(input cnt_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/lbh_if.sv */
`default_nettype none

// Request channel: one operation per transfer
interface lbh_req_if import lbh_pkg::*; ();
    logic    valid;
    logic    ready;
    func_t   func;
    sample_t sample;
    bucket_t read_index;

    modport source (output valid, func, sample, read_index, input ready);
    modport sink   (input valid, func, sample, read_index, output ready);
endinterface

// Response channel: one result per transfer
interface lbh_rsp_if import lbh_pkg::*; ();
    logic    valid;
    logic    ready;
    bucket_t bucket;
    out_t    count;
    out_t    max_count;
    logic    seen_nonzero;

    modport source (output valid, bucket, count, max_count, seen_nonzero, input ready);
    modport sink   (input valid, bucket, count, max_count, seen_nonzero, output ready);
endinterface
`default_nettype wire

/* hdl/lbh_front.sv */
`default_nettype none
module lbh_front import lbh_pkg::*; (
    lbh_req_if.sink  req,
    input  logic     scale_mode,
    input  q_stat_t  stat,
    output logic     push,
    output op_t      push_data
);

    logic                    is_zero;
    logic                    pow2_over;
    logic [POW2_BITS:0]      pow2_dec;
    logic [POW2_BITS-1:0]    pow2_m;
    bucket_t                 pow2_bits;
    bucket_t                 pow2_bucket;
    logic [DECADE_STEPS-1:0] dec_thermo;
    bucket_t                 dec_bucket;
    bucket_t                 rec_bucket;

    // Accept whenever the queue has room
    assign req.ready = !stat.full;
    assign push      = req.valid && req.ready;

    assign is_zero = (req.sample == '0);

    // Power-of-two: bucket = bit length of (v - 1) plus one
    assign pow2_over = (|req.sample[SAMPLE_W-1:POW2_BITS+1])
                    || (req.sample[POW2_BITS] && (|req.sample[POW2_BITS-1:0]));
    assign pow2_dec  = req.sample[POW2_BITS:0] - (POW2_BITS+1)'(1);
    assign pow2_m    = pow2_dec[POW2_BITS-1:0];

    always_comb
    begin
        pow2_bits = '0;
        for (int i = 0; i < POW2_BITS; i++)
        begin
            if (pow2_m[i])
                pow2_bits = bucket_t'(i + 1);
        end
    end

    assign pow2_bucket = is_zero   ? ZERO_BUCKET :
                         pow2_over ? OVF_BUCKET  :
                                     pow2_bits + bucket_t'(1);

    // Decade: parallel compares against every bound, count the passes
    always_comb
    begin
        for (int i = 0; i < DECADE_STEPS; i++)
            dec_thermo[i] = (req.sample >= DECADE_BOUND[i]);
    end

    assign dec_bucket = is_zero ? ZERO_BUCKET
                                : bucket_t'($countones(dec_thermo)) + bucket_t'(1);

    assign rec_bucket = scale_mode ? dec_bucket : pow2_bucket;

    // Queue entry: records carry their bucket, reads the requested index, others bucket zero
    always_comb
    begin
        push_data.func    = req.func;
        push_data.nonzero = !is_zero;
        case (req.func)
            FUNC_RECORD: push_data.bucket = rec_bucket;
            FUNC_READ:   push_data.bucket = req.read_index;
            default:     push_data.bucket = ZERO_BUCKET;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/lbh_queue.sv */
`default_nettype none
`include "assert_macros.svh"
module lbh_queue import lbh_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_t     push_data,
    input  logic    pop,
    output op_t     head,
    output q_stat_t stat
);

    op_t               entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;

    assign stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign head           = entries_reg[rd_ptr_reg];

    // Pointer wrap
    assign wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    `LBH_ASSERT_ALWAYS(a_q_bound, !rst_n || count_reg <= QCNT_W'(QUEUE_DEPTH))
    `LBH_ASSERT(a_q_no_overrun, push |-> !stat.full)
    `LBH_ASSERT(a_q_no_underrun, pop |-> stat.not_empty)

endmodule
`default_nettype wire

/* hdl/lbh_back.sv */
`default_nettype none
`include "assert_macros.svh"
module lbh_back import lbh_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  op_t      head,
    input  q_stat_t  stat,
    output logic     pop,
    lbh_rsp_if.source rsp
);

    cnt_t    counts_reg [NUM_BUCKETS];
    cnt_t    max_reg;
    logic    flag_reg;
    logic    out_valid_reg;
    bucket_t out_bucket_reg;
    out_t    out_count_reg;
    out_t    out_max_reg;
    logic    out_flag_reg;

    logic    in_range;
    cnt_t    cur;
    cnt_t    count_next;
    cnt_t    max_next;
    logic    flag_next;

    // Take the next operation when the result register is free or draining
    assign pop = stat.not_empty && (!out_valid_reg || rsp.ready);

    // Read-modify-write of the addressed counter
    assign in_range   = (head.bucket < bucket_t'(NUM_BUCKETS));
    assign cur        = in_range ? counts_reg[head.bucket] : '0;
    assign count_next = (cur == COUNT_MAX) ? cur : cur + cnt_t'(1);
    assign max_next   = (count_next > max_reg) ? count_next : max_reg;
    assign flag_next  = flag_reg || head.nonzero;

    // Histogram state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
                counts_reg[i] <= '0;
            max_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (pop)
            begin
                case (head.func)
                    FUNC_RECORD:
                    begin
                        counts_reg[head.bucket] <= count_next;
                        max_reg                 <= max_next;
                        flag_reg                <= flag_next;
                    end
                    FUNC_CLEAR:
                    begin
                        for (int i = 0; i < NUM_BUCKETS; i++)
                            counts_reg[i] <= '0;
                        max_reg  <= '0;
                        flag_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            case (head.func)
                FUNC_RECORD:
                begin
                    out_bucket_reg <= head.bucket;
                    out_count_reg  <= to_out(count_next);
                    out_max_reg    <= to_out(max_next);
                    out_flag_reg   <= flag_next;
                end
                FUNC_READ:
                begin
                    out_bucket_reg <= head.bucket;
                    out_count_reg  <= to_out(cur);
                    out_max_reg    <= to_out(max_reg);
                    out_flag_reg   <= flag_reg;
                end
                FUNC_CLEAR:
                begin
                    out_bucket_reg <= ZERO_BUCKET;
                    out_count_reg  <= '0;
                    out_max_reg    <= '0;
                    out_flag_reg   <= 1'b0;
                end
                default:
                begin
                    out_bucket_reg <= ZERO_BUCKET;
                    out_count_reg  <= '0;
                    out_max_reg    <= to_out(max_reg);
                    out_flag_reg   <= flag_reg;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.bucket       = out_bucket_reg;
    assign rsp.count        = out_count_reg;
    assign rsp.max_count    = out_max_reg;
    assign rsp.seen_nonzero = out_flag_reg;

    `LBH_ASSERT(a_clear_zeroes, pop && head.func == FUNC_CLEAR |=> max_reg == '0 && !flag_reg)
    `LBH_ASSERT(a_max_covers, pop && head.func == FUNC_RECORD |=> max_reg >= $past(count_next))
    `LBH_ASSERT(a_flag_sticky, flag_reg && !(pop && head.func == FUNC_CLEAR) |=> flag_reg)

endmodule
`default_nettype wire

/* hdl/log_bucket_histogram_unit.sv */
// Log-scale histogram of 18 saturating counters. A record transfer classifies
// a 64-bit sample into a power-of-two or decade bucket (scale_mode) and bumps
// that counter; a read transfer returns one bucket's count; a clear transfer
// zeroes all counters, the running maximum and the nonzero flag. Every request
// gives exactly one response. The front classifies in the accept cycle and
// pushes into a two-entry queue; the back does the counter read-modify-write
// and loads the response register in the same cycle, so the block sustains
// one request per cycle while rsp.ready stays high. A request passes through
// a queue entry and then the response register before its response is valid.
// The counter update in the back sets the request rate; a stalled response
// fills the queue and then drops req.ready. Counters are cleared by reset
// directly, with no clearing pass. Write scale_mode only while no request is
// in flight.
`default_nettype none
module log_bucket_histogram_unit import lbh_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    lbh_req_if.sink   req,
    lbh_rsp_if.source rsp
);

    logic    scale_mode_reg;
    logic    push;
    op_t     push_data;
    logic    pop;
    op_t     head;
    q_stat_t stat;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_mode_reg <= 1'b0;
        else if (cfg_wr_en)
            scale_mode_reg <= cfg_wr_data;
    end

    lbh_front u_front (
        .req        (req),
        .scale_mode (scale_mode_reg),
        .stat       (stat),
        .push       (push),
        .push_data  (push_data)
    );

    lbh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    lbh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .stat       (stat),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
`default_nettype wire
